// ===== hw/rtl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// Depends on nothing; bpa_bit_find and bitmap_page_allocator_unit import it.
package bpa_pkg;

    localparam int MAP_WORDS  = 1024;
    localparam int WORD_BITS  = 32;
    localparam int BIT_W      = 5;
    localparam int PAGE_W     = 15;
    localparam int WORD_IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic              mode;
        logic [PAGE_W-1:0] page_number;
    } t_in_word;

    typedef struct packed {
        logic [PAGE_W-1:0] page_index;
        t_status           status;
    } t_out_word;

    // Result of the lowest-set-bit search on one bitmap word.
    typedef struct packed {
        logic                 found;
        logic [BIT_W-1:0]     bit_idx;
        logic [WORD_BITS-1:0] cleared;
    } t_find;

endpackage

// ===== hw/rtl/bpa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bpa_bit_find.sv =====
// Lowest-set-bit finder for one bitmap word: index and the word with that bit cleared.
// Depends on bpa_pkg.
module bpa_bit_find
    import bpa_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    output t_find                o_find
);

    logic [WORD_BITS-1:0] low_bit;
    logic [BIT_W-1:0]     idx;

    // Two's complement isolates the lowest set bit; the one-hot is then encoded.
    assign low_bit = i_word & (~i_word + WORD_BITS'(1));

    always_comb begin
        idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low_bit[i]) begin
                idx = idx | BIT_W'(i);
            end
        end
    end

    assign o_find.found   = |i_word;
    assign o_find.bit_idx = idx;
    assign o_find.cleared = i_word & ~low_bit;

endmodule

// ===== hw/rtl/bitmap_page_allocator_unit.sv =====
// Top level of the bitmap page allocator: sequencer, bitmap RAM and bit finder.
// Depends on bpa_pkg, bpa_ram and bpa_bit_find.
//
// The allocator keeps one bit per page frame in a RAM of MAP_WORDS 32-bit words, where
// a set bit marks a free page. After reset the block runs a clearing pass over all
// MAP_WORDS words that marks every page reserved; input stays stalled until it is
// done. Software then frees each usable page once. A free word reads the bitmap word on
// acceptance, then ORs in the bit and writes it back once the output register is free;
// a page number beyond the map returns status 2 and leaves the map alone.
// An allocate word scans the bitmap circularly from the search cursor, one word per
// cycle through the single RAM read port while the output register is free, and
// examines from 1 up to MAP_WORDS words. The first nonzero word loses its lowest set
// bit and the page number word*32+bit is returned; a full circle of zero words returns
// status 1. The block works on one word at a time and is stalled while a request is in
// progress, but a finished result waits in the output register while the next request
// is already accepted; a request finishes only once that register is free.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE
    } t_state;

    localparam logic [WORD_IDX_W-1:0] LAST_WORD = WORD_IDX_W'(MAP_WORDS - 1);

    t_state                r_state, n_state;
    logic [WORD_IDX_W-1:0] r_clr_addr, n_clr_addr;
    logic [WORD_IDX_W-1:0] r_cursor, n_cursor;
    logic [WORD_IDX_W-1:0] r_scan_addr, n_scan_addr;
    logic [WORD_IDX_W-1:0] r_seen, n_seen;
    logic [WORD_IDX_W-1:0] r_free_addr, n_free_addr;
    logic [PAGE_W-1:0]     r_page, n_page;
    logic                  r_range, n_range;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;

    logic                  ram_we;
    logic [WORD_IDX_W-1:0] ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [WORD_IDX_W-1:0] ram_raddr;
    logic [WORD_BITS-1:0]  ram_rdata;
    t_find                 find;

    logic                  can_finish;
    logic [WORD_IDX_W-1:0] scan_next;
    logic [WORD_IDX_W-1:0] in_word_addr;
    logic                  in_out_of_range;
    logic [WORD_IDX_W+BIT_W-1:0] found_page;

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bpa_bit_find u_find (
        .i_word (ram_rdata),
        .o_find (find)
    );

    // A request may complete only when the output register is empty or being emptied.
    assign can_finish = !r_out_valid || !i_out_stall;

    assign scan_next       = (r_scan_addr == LAST_WORD) ? '0 : r_scan_addr + 1'b1;
    assign in_word_addr    = WORD_IDX_W'(i_in.page_number[PAGE_W-1:BIT_W]);
    assign in_out_of_range = 32'(i_in.page_number[PAGE_W-1:BIT_W]) >= MAP_WORDS;
    assign found_page      = {r_scan_addr, find.bit_idx};

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cursor    = r_cursor;
        n_scan_addr = r_scan_addr;
        n_seen      = r_seen;
        n_free_addr = r_free_addr;
        n_page      = r_page;
        n_range     = r_range;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_scan_addr;
        ram_wdata   = find.cleared;
        ram_raddr   = r_scan_addr;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.mode == MODE_ALLOC) begin
                        ram_raddr   = r_cursor;
                        n_scan_addr = r_cursor;
                        n_seen      = '0;
                        n_state     = S_SCAN;
                    end else begin
                        ram_raddr   = in_word_addr;
                        n_free_addr = in_word_addr;
                        n_page      = i_in.page_number;
                        n_range     = in_out_of_range;
                        n_state     = S_FREE;
                    end
                end
            end
            S_SCAN: begin
                // The read data belongs to r_scan_addr; holding re-reads the same word.
                if (can_finish) begin
                    if (find.found) begin
                        ram_we           = 1'b1;
                        ram_waddr        = r_scan_addr;
                        ram_wdata        = find.cleared;
                        n_cursor         = r_scan_addr;
                        n_out.page_index = PAGE_W'(found_page);
                        n_out.status     = ST_OK;
                        n_out_valid      = 1'b1;
                        n_state          = S_IDLE;
                    end else if (r_seen == LAST_WORD) begin
                        n_out.page_index = '0;
                        n_out.status     = ST_EMPTY;
                        n_out_valid      = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        ram_raddr   = scan_next;
                        n_scan_addr = scan_next;
                        n_seen      = r_seen + 1'b1;
                    end
                end
            end
            S_FREE: begin
                ram_raddr = r_free_addr;
                if (can_finish) begin
                    if (r_range) begin
                        n_out.status = ST_RANGE;
                    end else begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_free_addr;
                        ram_wdata    = ram_rdata | (WORD_BITS'(1) << r_page[BIT_W-1:0]);
                        n_cursor     = r_free_addr;
                        n_out.status = ST_OK;
                    end
                    n_out.page_index = r_page;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
        r_scan_addr <= n_scan_addr;
        r_seen      <= n_seen;
        r_free_addr <= n_free_addr;
        r_page      <= n_page;
        r_range     <= n_range;
        r_out       <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // No request is taken while the bitmap is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> o_in_stall)
        else $error("input accepted during clearing pass");

    // A bitmap write during a scan is the allocation and always yields a result.
    a_scan_write_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && (r_state == S_SCAN)) |=> (o_out_valid && (o_out.status == ST_OK)))
        else $error("scan wrote the bitmap without an ok result");

    // The search cursor always points inside the map.
    a_cursor_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |-> (r_cursor <= LAST_WORD))
        else $error("search cursor outside the map");

    // A scan never examines more words than the map holds.
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_seen <= LAST_WORD))
        else $error("scan ran past one full circle");
`endif

endmodule
